[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define QNA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define QNA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/qna_pkg.sv]
// ----------------------------------------------------------------------------
// Quaternion normalize package
// Widths, constants and the data records that travel along the cell chains.
// ----------------------------------------------------------------------------
package qna_pkg;

  localparam int unsigned SQRT_STEPS   = 64;
  localparam int unsigned DIV_STEPS    = 32;
  localparam int unsigned CORDIC_STEPS = 18;
  localparam int unsigned LANES        = 7;
  localparam int unsigned CORDIC_W     = 40;

  localparam logic [31:0] ONE_Q30   = 32'h4000_0000;
  localparam logic [15:0] ANGLE_MAX = 16'd46080;
  localparam logic signed [31:0] Z_NEG_START = 32'sd5898240;

  // Arctangent of 2^-k in degrees, Q16.16.
  localparam logic signed [31:0] ATAN_DEG [CORDIC_STEPS] = '{
    32'sd2949120, 32'sd1740967, 32'sd919879, 32'sd466945, 32'sd234379,
    32'sd117304,  32'sd58666,   32'sd29335,  32'sd14668,  32'sd7334,
    32'sd3667,    32'sd1833,    32'sd917,    32'sd458,    32'sd229,
    32'sd115,     32'sd57,      32'sd29
  };

  typedef struct packed {
    logic [3:0][31:0] mag;
    logic [3:0]       neg;
    logic             zero;
    logic [64:0]      s4;
    logic [64:0]      sv;
    logic [66:0]      rem4;
    logic [66:0]      remv;
    logic [63:0]      root4;
    logic [63:0]      rootv;
  } qna_sq_t;

  typedef struct packed {
    logic [3:0]             neg;
    logic                   zero;
    logic [63:0]            r4;
    logic [63:0]            rv;
    logic [31:0]            mag0;
    logic [LANES-1:0][63:0] rem;
    logic [LANES-1:0][31:0] quo;
  } qna_dv_t;

  typedef struct packed {
    logic                       zero;
    logic                       axis_undef;
    logic [LANES-1:0][31:0]     res;
    logic signed [CORDIC_W-1:0] x;
    logic signed [CORDIC_W-1:0] y;
    logic signed [31:0]         z;
  } qna_cr_t;

endpackage

[rtl/core/qna_if.sv]
// ----------------------------------------------------------------------------
// Quaternion normalize channels
// Request channels for raw quaternions and for normalized results.
// ----------------------------------------------------------------------------
interface qna_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] q_w;
  logic signed [31:0] q_x;
  logic signed [31:0] q_y;
  logic signed [31:0] q_z;

  modport source (output valid, output q_w, output q_x, output q_y, output q_z,
                  input ready);
  modport sink (input valid, input q_w, input q_x, input q_y, input q_z,
                output ready);
endinterface

interface qna_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] norm_w;
  logic signed [31:0] norm_x;
  logic signed [31:0] norm_y;
  logic signed [31:0] norm_z;
  logic signed [31:0] axis_x;
  logic signed [31:0] axis_y;
  logic signed [31:0] axis_z;
  logic [15:0]        angle_deg;
  logic               zero_norm;
  logic               axis_undefined;

  modport source (output valid, output norm_w, output norm_x, output norm_y,
                  output norm_z, output axis_x, output axis_y, output axis_z,
                  output angle_deg, output zero_norm, output axis_undefined,
                  input ready);
  modport sink (input valid, input norm_w, input norm_x, input norm_y,
                input norm_z, input axis_x, input axis_y, input axis_z,
                input angle_deg, input zero_norm, input axis_undefined,
                output ready);
endinterface

[rtl/core/qna_sqrt_cell.sv]
// ----------------------------------------------------------------------------
// Square root cell
// One digit step of the two integer square roots, four and three components.
// ----------------------------------------------------------------------------
module qna_sqrt_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             valid_i,
  input  qna_pkg::qna_sq_t data_i,
  output logic             valid_o,
  output qna_pkg::qna_sq_t data_o
);
  import qna_pkg::*;

  localparam int unsigned BIT_HI = 127 - 2 * IDX;

  logic [127:0] x4;
  logic [127:0] xv;
  logic [66:0]  r4;
  logic [66:0]  rv;
  logic [66:0]  t4;
  logic [66:0]  tv;
  qna_sq_t      data_nxt;
  qna_sq_t      data_r;
  logic         valid_r;

  always_comb begin
    x4 = {1'b0, data_i.s4, 62'd0};
    xv = {1'b0, data_i.sv, 62'd0};
    r4 = {data_i.rem4[64:0], x4[BIT_HI -: 2]};
    rv = {data_i.remv[64:0], xv[BIT_HI -: 2]};
    t4 = {1'b0, data_i.root4, 2'b01};
    tv = {1'b0, data_i.rootv, 2'b01};
    data_nxt = data_i;
    if (r4 >= t4) begin
      data_nxt.rem4  = r4 - t4;
      data_nxt.root4 = {data_i.root4[62:0], 1'b1};
    end else begin
      data_nxt.rem4  = r4;
      data_nxt.root4 = {data_i.root4[62:0], 1'b0};
    end
    if (rv >= tv) begin
      data_nxt.remv  = rv - tv;
      data_nxt.rootv = {data_i.rootv[62:0], 1'b1};
    end else begin
      data_nxt.remv  = rv;
      data_nxt.rootv = {data_i.rootv[62:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
    if (en) begin
      data_r <= data_nxt;
    end
  end

  assign valid_o = valid_r;
  assign data_o  = data_r;

endmodule

[rtl/core/qna_div_cell.sv]
// ----------------------------------------------------------------------------
// Division cell
// One restoring quotient bit for each of the seven scaled component lanes.
// ----------------------------------------------------------------------------
module qna_div_cell (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             valid_i,
  input  qna_pkg::qna_dv_t data_i,
  output logic             valid_o,
  output qna_pkg::qna_dv_t data_o
);
  import qna_pkg::*;

  logic [64:0] r2;
  logic [64:0] dd;
  qna_dv_t     data_nxt;
  qna_dv_t     data_r;
  logic        valid_r;

  always_comb begin
    data_nxt = data_i;
    r2 = '0;
    dd = '0;
    for (int l = 0; l < LANES; l++) begin
      dd = (l < 4) ? {1'b0, data_i.r4} : {1'b0, data_i.rv};
      r2 = {data_i.rem[l], 1'b0};
      if (r2 >= dd) begin
        r2 = r2 - dd;
        data_nxt.quo[l] = {data_i.quo[l][30:0], 1'b1};
      end else begin
        data_nxt.quo[l] = {data_i.quo[l][30:0], 1'b0};
      end
      data_nxt.rem[l] = r2[63:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
    if (en) begin
      data_r <= data_nxt;
    end
  end

  assign valid_o = valid_r;
  assign data_o  = data_r;

endmodule

[rtl/core/qna_cordic_cell.sv]
// ----------------------------------------------------------------------------
// CORDIC cell
// One vectoring rotation that drives y toward zero and accumulates the angle.
// ----------------------------------------------------------------------------
module qna_cordic_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             valid_i,
  input  qna_pkg::qna_cr_t data_i,
  output logic             valid_o,
  output qna_pkg::qna_cr_t data_o
);
  import qna_pkg::*;

  logic signed [CORDIC_W-1:0] nx;
  logic signed [CORDIC_W-1:0] ny;
  logic signed [CORDIC_W-1:0] dx;
  logic signed [CORDIC_W-1:0] dy;
  qna_cr_t                    data_nxt;
  qna_cr_t                    data_r;
  logic                       valid_r;

  always_comb begin
    nx = -data_i.x;
    ny = -data_i.y;
    dx = data_i.y[CORDIC_W-1] ? -(ny >>> IDX) : (data_i.y >>> IDX);
    dy = data_i.x[CORDIC_W-1] ? -(nx >>> IDX) : (data_i.x >>> IDX);
    data_nxt = data_i;
    if (data_i.y > 0) begin
      data_nxt.x = data_i.x + dx;
      data_nxt.y = data_i.y - dy;
      data_nxt.z = data_i.z + ATAN_DEG[IDX];
    end else begin
      data_nxt.x = data_i.x - dx;
      data_nxt.y = data_i.y + dy;
      data_nxt.z = data_i.z - ATAN_DEG[IDX];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
    if (en) begin
      data_r <= data_nxt;
    end
  end

  assign valid_o = valid_r;
  assign data_o  = data_r;

endmodule

[rtl/core/quaternion_normalize_axis_angle_unit.sv]
// Throughput: one request per cycle while the output is not stalled; the whole pipeline advances together.
// Depth is set by the 64-cell square root chain, the 32-cell divider chain
// and the 18-cell CORDIC chain, plus four front stages and two back stages.
// Reset is synchronous and active low; it clears all valid bits only.
// ----------------------------------------------------------------------------
// Quaternion normalize and axis-angle unit
// Normalizes a Q2.30 quaternion, extracts its unit axis and acos(w) angle.
// ----------------------------------------------------------------------------
module quaternion_normalize_axis_angle_unit (
  input logic        clk,
  input logic        rst_n,
  qna_in_if.sink     in_if,
  qna_out_if.source  out_if
);
  import qna_pkg::*;
  `include "assert_macros.svh"

  logic adv;

  logic             a_valid_r;
  logic [3:0][31:0] a_mag_r;
  logic [3:0]       a_neg_r;
  logic             a_zero_r;
  logic [3:0][31:0] a_mag_nxt;

  logic             b_valid_r;
  logic [3:0][31:0] b_mag_r;
  logic [3:0]       b_neg_r;
  logic             b_zero_r;
  logic [31:0]      or_mag;
  logic [4:0]       shift_k;

  logic             c_valid_r;
  logic [3:0][31:0] c_mag_r;
  logic [3:0]       c_neg_r;
  logic             c_zero_r;
  logic [3:0][63:0] c_sq_r;

  logic             d_valid_r;
  qna_sq_t          d_data_r;
  qna_sq_t          d_data_nxt;

  logic    sq_valid [SQRT_STEPS+1];
  qna_sq_t sq_data  [SQRT_STEPS+1];
  logic    dv_valid [DIV_STEPS+1];
  qna_dv_t dv_data  [DIV_STEPS+1];
  logic    cr_valid [CORDIC_STEPS+1];
  qna_cr_t cr_data  [CORDIC_STEPS+1];

  logic        e_valid_r;
  qna_cr_t     e_data_r;
  qna_cr_t     e_data_nxt;
  logic [32:0] qp1;
  logic [31:0] half;
  logic [31:0] sat;
  logic        lane_neg;

  logic                   out_valid_r;
  logic [LANES-1:0][31:0] out_res_r;
  logic [15:0]            out_angle_r;
  logic                   out_zero_r;
  logic                   out_axis_undef_r;
  logic [LANES-1:0][31:0] out_res_nxt;
  logic [15:0]            out_angle_nxt;
  logic signed [31:0]     ang_full;
  qna_cr_t                fin;

  assign adv         = !out_valid_r || out_if.ready;
  assign in_if.ready = adv;

  // Stage A: magnitudes and signs.
  assign a_mag_nxt[0] = in_if.q_w[31] ? (~in_if.q_w + 32'd1) : in_if.q_w;
  assign a_mag_nxt[1] = in_if.q_x[31] ? (~in_if.q_x + 32'd1) : in_if.q_x;
  assign a_mag_nxt[2] = in_if.q_y[31] ? (~in_if.q_y + 32'd1) : in_if.q_y;
  assign a_mag_nxt[3] = in_if.q_z[31] ? (~in_if.q_z + 32'd1) : in_if.q_z;

  // Stage B: common left shift that brings the leading bit of the largest magnitude up to bit 30.
  always_comb begin
    or_mag  = a_mag_r[0] | a_mag_r[1] | a_mag_r[2] | a_mag_r[3];
    shift_k = 5'd0;
    if (or_mag[31:30] == 2'b00) begin
      for (int i = 0; i < 30; i++) begin
        if (or_mag[i]) begin
          shift_k = 5'(30 - i);
        end
      end
    end
  end

  // Stage D: sums of squares seed the square root chain.
  always_comb begin
    d_data_nxt       = '0;
    d_data_nxt.mag   = c_mag_r;
    d_data_nxt.neg   = c_neg_r;
    d_data_nxt.zero  = c_zero_r;
    d_data_nxt.sv    = {1'b0, c_sq_r[1]} + {1'b0, c_sq_r[2]} + {1'b0, c_sq_r[3]};
    d_data_nxt.s4    = d_data_nxt.sv + {1'b0, c_sq_r[0]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
      d_valid_r <= 1'b0;
    end else if (adv) begin
      a_valid_r <= in_if.valid;
      b_valid_r <= a_valid_r;
      c_valid_r <= b_valid_r;
      d_valid_r <= c_valid_r;
    end
    if (adv) begin
      a_mag_r  <= a_mag_nxt;
      a_neg_r  <= {in_if.q_z[31], in_if.q_y[31], in_if.q_x[31], in_if.q_w[31]};
      a_zero_r <= (a_mag_nxt == '0);
      for (int i = 0; i < 4; i++) begin
        b_mag_r[i] <= a_mag_r[i] << shift_k;
        c_sq_r[i]  <= 64'(b_mag_r[i]) * 64'(b_mag_r[i]);
      end
      b_neg_r  <= a_neg_r;
      b_zero_r <= a_zero_r;
      c_mag_r  <= b_mag_r;
      c_neg_r  <= b_neg_r;
      c_zero_r <= b_zero_r;
      d_data_r <= d_data_nxt;
    end
  end

  assign sq_valid[0] = d_valid_r;
  assign sq_data[0]  = d_data_r;

  for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
    qna_sqrt_cell #(.IDX(g)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (adv),
      .valid_i (sq_valid[g]),
      .data_i  (sq_data[g]),
      .valid_o (sq_valid[g+1]),
      .data_o  (sq_data[g+1])
    );
  end

  always_comb begin
    dv_data[0]      = '0;
    dv_data[0].neg  = sq_data[SQRT_STEPS].neg;
    dv_data[0].zero = sq_data[SQRT_STEPS].zero;
    dv_data[0].r4   = sq_data[SQRT_STEPS].root4;
    dv_data[0].rv   = sq_data[SQRT_STEPS].rootv;
    dv_data[0].mag0 = sq_data[SQRT_STEPS].mag[0];
    for (int l = 0; l < 4; l++) begin
      dv_data[0].rem[l] = {2'b00, sq_data[SQRT_STEPS].mag[l], 30'd0};
    end
    for (int l = 4; l < LANES; l++) begin
      dv_data[0].rem[l] = {2'b00, sq_data[SQRT_STEPS].mag[l-3], 30'd0};
    end
  end
  assign dv_valid[0] = sq_valid[SQRT_STEPS];

  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
    qna_div_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (adv),
      .valid_i (dv_valid[g]),
      .data_i  (dv_data[g]),
      .valid_o (dv_valid[g+1]),
      .data_o  (dv_data[g+1])
    );
  end

  // Stage E: rounding, saturation and sign, plus the CORDIC start vector.
  always_comb begin
    e_data_nxt            = '0;
    e_data_nxt.zero       = dv_data[DIV_STEPS].zero;
    e_data_nxt.axis_undef = (dv_data[DIV_STEPS].rv == '0);
    qp1      = '0;
    half     = '0;
    sat      = '0;
    lane_neg = 1'b0;
    for (int l = 0; l < LANES; l++) begin
      qp1      = {1'b0, dv_data[DIV_STEPS].quo[l]} + 33'd1;
      half     = qp1[32:1];
      sat      = (half > ONE_Q30) ? ONE_Q30 : half;
      lane_neg = (l < 4) ? dv_data[DIV_STEPS].neg[l] : dv_data[DIV_STEPS].neg[l-3];
      e_data_nxt.res[l] = lane_neg ? (~sat + 32'd1) : sat;
    end
    if (dv_data[DIV_STEPS].neg[0]) begin
      e_data_nxt.x = {5'd0, dv_data[DIV_STEPS].rv[63:29]};
      e_data_nxt.y = {6'd0, dv_data[DIV_STEPS].mag0, 2'b00};
      e_data_nxt.z = Z_NEG_START;
    end else begin
      e_data_nxt.x = {6'd0, dv_data[DIV_STEPS].mag0, 2'b00};
      e_data_nxt.y = {5'd0, dv_data[DIV_STEPS].rv[63:29]};
      e_data_nxt.z = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_valid_r <= 1'b0;
    end else if (adv) begin
      e_valid_r <= dv_valid[DIV_STEPS];
    end
    if (adv) begin
      e_data_r <= e_data_nxt;
    end
  end

  assign cr_valid[0] = e_valid_r;
  assign cr_data[0]  = e_data_r;

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
    qna_cordic_cell #(.IDX(g)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (adv),
      .valid_i (cr_valid[g]),
      .data_i  (cr_data[g]),
      .valid_o (cr_valid[g+1]),
      .data_o  (cr_data[g+1])
    );
  end

  // Output stage: angle rounding and the zero-norm and zero-axis cases.
  always_comb begin
    fin      = cr_data[CORDIC_STEPS];
    ang_full = (fin.z + 32'sd128) >>> 8;
    if (fin.z <= 0) begin
      out_angle_nxt = '0;
    end else if (ang_full > $signed({16'd0, ANGLE_MAX})) begin
      out_angle_nxt = ANGLE_MAX;
    end else begin
      out_angle_nxt = ang_full[15:0];
    end
    out_res_nxt = fin.res;
    if (fin.axis_undef) begin
      for (int l = 4; l < LANES; l++) begin
        out_res_nxt[l] = '0;
      end
    end
    if (fin.zero) begin
      out_res_nxt   = '0;
      out_angle_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= cr_valid[CORDIC_STEPS];
    end
    if (adv) begin
      out_res_r        <= out_res_nxt;
      out_angle_r      <= out_angle_nxt;
      out_zero_r       <= fin.zero;
      out_axis_undef_r <= fin.axis_undef || fin.zero;
    end
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.norm_w         = out_res_r[0];
  assign out_if.norm_x         = out_res_r[1];
  assign out_if.norm_y         = out_res_r[2];
  assign out_if.norm_z         = out_res_r[3];
  assign out_if.axis_x         = out_res_r[4];
  assign out_if.axis_y         = out_res_r[5];
  assign out_if.axis_z         = out_res_r[6];
  assign out_if.angle_deg      = out_angle_r;
  assign out_if.zero_norm      = out_zero_r;
  assign out_if.axis_undefined = out_axis_undef_r;

  `QNA_ASSERT_SAME(a_zero_clears, out_valid_r && out_zero_r, out_axis_undef_r && out_angle_r == 16'd0 && out_res_r == '0, "zero quaternion gave a nonzero result")
  `QNA_ASSERT_SAME(a_axis_zeroed, out_valid_r && out_axis_undef_r, out_res_r[4] == '0 && out_res_r[5] == '0 && out_res_r[6] == '0, "undefined axis is not zero")
  `QNA_ASSERT_SAME(a_angle_range, out_valid_r, out_angle_r <= ANGLE_MAX, "angle above 180 degrees")
  `QNA_ASSERT_NEXT(a_no_drop, out_valid_r && !out_if.ready, out_valid_r && $stable(out_res_r), "stalled result was lost")

endmodule
